/* sv/vnapf_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the vertex node area/perimeter force block.
// No dependencies; every other file but the port checker imports this package.
package vnapf_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ROOT_STEPS    = 32;

    // Queue between the front end and the back end.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_AREA_PARAM  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIM_PARAM = 1'b1;

    // One classified word as it waits in the queue.
    typedef struct packed {
        logic signed [32:0] cw_dx;
        logic signed [32:0] cw_dy;
        logic signed [32:0] aw_dx;
        logic signed [32:0] aw_dy;
        logic [30:0]        area;
        logic [30:0]        perim;
        logic               area_zero;
        logic               last;
    } vnapf_entry_t;

    // Commands from the back end sequencer to the shared root/divide unit.
    typedef struct packed {
        logic start_root;
        logic start_div;
    } vnapf_rd_ctl_t;

endpackage

/* sv/vertex_node_area_perimeter_force.sv */
`timescale 1ns / 1ps
// Top level of the vertex node area/perimeter force accumulator.
// Depends on vnapf_pkg, vnapf_front, vnapf_fifo and vnapf_back.
//
// Usage: each input word on the in_valid/in_ready channel is one pair of a
// node and an element that contains it. Words of the same node arrive back
// to back; the word with last_elem set closes the node, and one output word
// with the saturated total force and the error flag leaves on the
// out_valid/out_ready channel. Other words give no output.
// The front end classifies each word in the cycle it is accepted and parks
// it in a two-entry queue, so up to two words are taken while the back end
// is busy or while a finished total waits for the receiver.
// The back end works on one word at a time. It uses the shared root/divide
// unit for three 32-step square roots, up to three FRAC_BITS+1 step divisions
// and one 32+FRAC_BITS step division for the area term; a word that closes a
// node also passes through the emit state. The area division is skipped when
// the area is zero, and a unit-vector division when its vector has zero length.
// When the receiver stalls, the total is held and the back end waits before
// emitting the next one. Reset clears the queue, the running sums and the error
// flag, and sets both coefficients to 1.0.
// Configuration (cfg_we, cfg_addr, cfg_wdata) must be written while idle.
module vertex_node_area_perimeter_force #(
    parameter int FRAC_BITS = vnapf_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vnapf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                       cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [31:0]                node_x,
    input  logic signed [31:0]                node_y,
    input  logic signed [31:0]                prev_x,
    input  logic signed [31:0]                prev_y,
    input  logic signed [31:0]                next_x,
    input  logic signed [31:0]                next_y,
    input  logic [30:0]                       elem_area,
    input  logic [30:0]                       elem_perimeter,
    input  logic                              last_elem,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                force_x,
    output logic signed [31:0]                force_y,
    output logic                              math_error
);
    import vnapf_pkg::*;

    logic signed [31:0] area_param_reg;
    logic signed [31:0] perim_param_reg;

    logic               push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    vnapf_entry_t       front_entry;
    vnapf_entry_t       q_entry;

    // Coefficient registers, reset to 1.0 in the chosen fixed-point format.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_param_reg  <= DATA_W'(1) << FRAC_BITS;
            perim_param_reg <= DATA_W'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_AREA_PARAM:  area_param_reg  <= cfg_wdata;
                REG_PERIM_PARAM: perim_param_reg <= cfg_wdata;
                default:         area_param_reg  <= area_param_reg;
            endcase
        end
    end

    vnapf_front u_front (
        .in_valid       (in_valid),
        .q_full         (q_full),
        .node_x         (node_x),
        .node_y         (node_y),
        .prev_x         (prev_x),
        .prev_y         (prev_y),
        .next_x         (next_x),
        .next_y         (next_y),
        .elem_area      (elem_area),
        .elem_perimeter (elem_perimeter),
        .last_elem      (last_elem),
        .in_ready       (in_ready),
        .push           (push),
        .entry          (front_entry)
    );

    vnapf_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_entry),
        .full  (q_full),
        .valid (q_valid),
        .pop   (q_pop),
        .dout  (q_entry)
    );

    vnapf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .q_pop           (q_pop),
        .area_param      (area_param_reg),
        .perimeter_param (perim_param_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .force_x         (force_x),
        .force_y         (force_y),
        .math_error      (math_error)
    );

endmodule

/* sv/vnapf_fifo.sv */
`timescale 1ns / 1ps
// Short queue that decouples the front end from the back end.
// Depends on vnapf_pkg for the entry type and depth.
module vnapf_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  vnapf_pkg::vnapf_entry_t din,
    output logic                   full,
    output logic                   valid,
    input  logic                   pop,
    output vnapf_pkg::vnapf_entry_t dout
);
    import vnapf_pkg::*;

    vnapf_entry_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W:0]     cnt_reg;

    assign full  = (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

/* sv/vnapf_front.sv */
`timescale 1ns / 1ps
// Front end: takes an input word, forms the edge vectors and flags.
// Depends on vnapf_pkg for the entry type.
module vnapf_front (
    input  logic                    in_valid,
    input  logic                    q_full,
    input  logic signed [31:0]      node_x,
    input  logic signed [31:0]      node_y,
    input  logic signed [31:0]      prev_x,
    input  logic signed [31:0]      prev_y,
    input  logic signed [31:0]      next_x,
    input  logic signed [31:0]      next_y,
    input  logic [30:0]             elem_area,
    input  logic [30:0]             elem_perimeter,
    input  logic                    last_elem,
    output logic                    in_ready,
    output logic                    push,
    output vnapf_pkg::vnapf_entry_t entry
);
    import vnapf_pkg::*;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Differences need one extra bit to cover the full signed range.
    always_comb
    begin
        entry.cw_dx     = 33'(prev_x) - 33'(node_x);
        entry.cw_dy     = 33'(prev_y) - 33'(node_y);
        entry.aw_dx     = 33'(next_x) - 33'(node_x);
        entry.aw_dy     = 33'(next_y) - 33'(node_y);
        entry.area      = elem_area;
        entry.perim     = elem_perimeter;
        entry.area_zero = (elem_area == '0);
        entry.last      = last_elem;
    end

endmodule

/* sv/vnapf_root_div.sv */
`timescale 1ns / 1ps
// Shared iterative unit: 64-bit integer square root (two bits per step)
// and a two-lane restoring divider with a common divisor. Uses vnapf_pkg.
module vnapf_root_div #(
    parameter int DW = 48,
    parameter int CW = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  vnapf_pkg::vnapf_rd_ctl_t ctl,
    input  logic [63:0]              sq_in,
    input  logic [31:0]              div_d,
    input  logic [31:0]              rem_x_init,
    input  logic [31:0]              rem_y_init,
    input  logic [DW-1:0]            acc_x_init,
    input  logic [DW-1:0]            acc_y_init,
    input  logic [CW-1:0]            div_n,
    output logic                     done,
    output logic [31:0]              root,
    output logic [DW-1:0]            quo_x,
    output logic [DW-1:0]            quo_y
);
    import vnapf_pkg::*;

    typedef enum logic {M_ROOT, M_DIV} mode_t;

    mode_t          mode_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  cnt_reg;

    logic [63:0]    v_reg;
    logic [63:0]    res_reg;
    logic [63:0]    rbit_reg;
    logic [31:0]    d_reg;
    logic [31:0]    rem_x_reg;
    logic [31:0]    rem_y_reg;
    logic [DW-1:0]  acc_x_reg;
    logic [DW-1:0]  acc_y_reg;

    logic [63:0]    trial;
    logic           root_ge;
    logic [32:0]    sh_x;
    logic [32:0]    sh_y;
    logic [32:0]    diff_x;
    logic [32:0]    diff_y;
    logic           ge_x;
    logic           ge_y;

    assign done  = done_reg;
    assign root  = res_reg[31:0];
    assign quo_x = acc_x_reg;
    assign quo_y = acc_y_reg;

    always_comb
    begin
        trial   = res_reg + rbit_reg;
        root_ge = (v_reg >= trial);
        sh_x    = {rem_x_reg, acc_x_reg[DW-1]};
        sh_y    = {rem_y_reg, acc_y_reg[DW-1]};
        diff_x  = sh_x - {1'b0, d_reg};
        diff_y  = sh_y - {1'b0, d_reg};
        ge_x    = (sh_x >= {1'b0, d_reg});
        ge_y    = (sh_y >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_ROOT;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start_root)
            begin
                mode_reg <= M_ROOT;
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ROOT_STEPS);
            end
            else if (ctl.start_div)
            begin
                mode_reg <= M_DIV;
                busy_reg <= 1'b1;
                cnt_reg  <= div_n;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start_root)
        begin
            v_reg    <= sq_in;
            res_reg  <= '0;
            rbit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (ctl.start_div)
        begin
            d_reg     <= div_d;
            rem_x_reg <= rem_x_init;
            rem_y_reg <= rem_y_init;
            acc_x_reg <= acc_x_init;
            acc_y_reg <= acc_y_init;
        end
        else if (busy_reg)
        begin
            case (mode_reg)
                M_ROOT:
                begin
                    if (root_ge)
                    begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + rbit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    rbit_reg <= rbit_reg >> 2;
                end
                M_DIV:
                begin
                    rem_x_reg <= ge_x ? diff_x[31:0] : sh_x[31:0];
                    rem_y_reg <= ge_y ? diff_y[31:0] : sh_y[31:0];
                    acc_x_reg <= {acc_x_reg[DW-2:0], ge_x};
                    acc_y_reg <= {acc_y_reg[DW-2:0], ge_y};
                end
                default:
                begin
                    res_reg <= res_reg;
                end
            endcase
        end
    end

endmodule

/* sv/vnapf_back.sv */
`timescale 1ns / 1ps
// Back end: sequencer that turns one queued word into a force contribution,
// accumulates it and emits the node total. Uses vnapf_pkg and vnapf_root_div.
module vnapf_back #(
    parameter int FRAC_BITS = vnapf_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  vnapf_pkg::vnapf_entry_t q_entry,
    output logic                    q_pop,
    input  logic signed [31:0]      area_param,
    input  logic signed [31:0]      perimeter_param,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      force_x,
    output logic signed [31:0]      force_y,
    output logic                    math_error
);
    import vnapf_pkg::*;

    localparam int UW   = FRAC_BITS + 2;
    localparam int SW_S = FRAC_BITS + 3;
    localparam int DW   = DATA_W + FRAC_BITS;
    localparam int CW   = $clog2(DW + 1);
    localparam int AW   = DATA_W + UW;
    localparam int MW   = DATA_W + SW_S;
    localparam int TW   = DW + 3;
    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SQA, S_SQB, S_ROOT, S_DIV, S_AMX, S_AMY,
        S_ADIV, S_TENS, S_MX, S_MY, S_ACC, S_EMIT
    } state_t;

    typedef enum logic [1:0] {VEC_CW, VEC_ACW, VEC_NRM} vec_t;

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > S32_MAX)
        begin
            r = {1'b1, 32'h7FFF_FFFF};
        end
        else if (v < S32_MIN)
        begin
            r = {1'b1, 32'h8000_0000};
        end
        else
        begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    state_t                state_reg;
    vec_t                  vec_reg;
    vnapf_entry_t          ent_reg;
    logic [31:0]           ax_reg;
    logic [31:0]           ay_reg;
    logic                  sgx_reg;
    logic                  sgy_reg;
    logic [61:0]           sq_reg;
    logic signed [UW-1:0]  cwx_reg;
    logic signed [UW-1:0]  cwy_reg;
    logic signed [UW-1:0]  awx_reg;
    logic signed [UW-1:0]  awy_reg;
    logic signed [UW-1:0]  nrx_reg;
    logic signed [UW-1:0]  nry_reg;
    logic [DW-1:0]         prod_reg;
    logic                  negx_reg;
    logic                  negy_reg;
    logic signed [DW:0]    defx_reg;
    logic signed [DW:0]    defy_reg;
    logic signed [31:0]    m_reg;
    logic signed [33:0]    memx_reg;
    logic signed [33:0]    memy_reg;
    logic signed [31:0]    sum_x_reg;
    logic signed [31:0]    sum_y_reg;
    logic                  err_reg;
    logic                  out_valid_reg;
    logic signed [31:0]    force_x_reg;
    logic signed [31:0]    force_y_reg;
    logic                  math_error_reg;

    logic signed [SW_S-1:0] snx;
    logic signed [SW_S-1:0] sny;
    logic signed [SW_S-1:0] nsx;
    logic signed [SW_S-1:0] nsy;
    logic signed [32:0]     sel_dx;
    logic signed [32:0]     sel_dy;
    logic [32:0]            mag_x;
    logic [32:0]            mag_y;
    logic                   halve;
    logic [61:0]            ax_sq;
    logic [61:0]            ay_sq;
    logic [62:0]            sq_sum;
    logic signed [UW-1:0]   ux_mag;
    logic signed [UW-1:0]   uy_mag;
    logic signed [UW-1:0]   ux_val;
    logic signed [UW-1:0]   uy_val;
    logic signed [AW-1:0]   pa;
    logic [AW-1:0]          pa_mag;
    logic signed [DW:0]     qx_mag;
    logic signed [DW:0]     qy_mag;
    logic signed [63:0]     pm;
    logic signed [63:0]     pm_sh;
    logic [32:0]            m_sat;
    logic signed [MW-1:0]   ms;
    logic signed [MW-1:0]   ms_sh;
    logic signed [TW-1:0]   tx;
    logic signed [TW-1:0]   ty;
    logic [32:0]            tx_sat;
    logic [32:0]            ty_sat;

    vnapf_rd_ctl_t          rd_ctl;
    logic                   rd_done;
    logic [31:0]            rd_root;
    logic [DW-1:0]          rd_qx;
    logic [DW-1:0]          rd_qy;
    logic [31:0]            rd_d;
    logic [31:0]            rd_rem;
    logic [DW-1:0]          rd_acc_x;
    logic [DW-1:0]          rd_acc_y;
    logic [CW-1:0]          rd_n;

    assign out_valid  = out_valid_reg;
    assign force_x    = force_x_reg;
    assign force_y    = force_y_reg;
    assign math_error = math_error_reg;
    assign q_pop      = (state_reg == S_IDLE) && q_valid;

    always_comb
    begin
        snx = SW_S'(cwx_reg) + SW_S'(awx_reg);
        sny = SW_S'(cwy_reg) + SW_S'(awy_reg);
        nsx = -snx;
        nsy = -sny;
        case (vec_reg)
            VEC_CW:
            begin
                sel_dx = ent_reg.cw_dx;
                sel_dy = ent_reg.cw_dy;
            end
            VEC_ACW:
            begin
                sel_dx = ent_reg.aw_dx;
                sel_dy = ent_reg.aw_dy;
            end
            VEC_NRM:
            begin
                sel_dx = 33'(nsx);
                sel_dy = 33'(nsy);
            end
            default:
            begin
                sel_dx = '0;
                sel_dy = '0;
            end
        endcase
        mag_x = sel_dx[32] ? 33'(-sel_dx) : 33'(sel_dx);
        mag_y = sel_dy[32] ? 33'(-sel_dy) : 33'(sel_dy);
        // Both magnitudes are halved together, once, if either does not fit in 31 bits.
        halve = mag_x[32] | mag_x[31] | mag_y[32] | mag_y[31];

        ax_sq  = ax_reg[30:0] * ax_reg[30:0];
        ay_sq  = ay_reg[30:0] * ay_reg[30:0];
        sq_sum = 63'(sq_reg) + 63'(ay_sq);

        ux_mag = UW'({1'b0, rd_qx[FRAC_BITS:0]});
        uy_mag = UW'({1'b0, rd_qy[FRAC_BITS:0]});
        ux_val = sgx_reg ? -ux_mag : ux_mag;
        uy_val = sgy_reg ? -uy_mag : uy_mag;

        pa     = (state_reg == S_AMX) ? AW'(area_param) * AW'(nrx_reg)
                                      : AW'(area_param) * AW'(nry_reg);
        pa_mag = pa[AW-1] ? AW'(-pa) : AW'(pa);
        qx_mag = {1'b0, rd_qx};
        qy_mag = {1'b0, rd_qy};

        pm    = 64'(perimeter_param) * 64'(signed'({1'b0, ent_reg.perim}));
        pm_sh = pm >>> FRAC_BITS;
        m_sat = sat32(pm_sh);

        ms    = (state_reg == S_MX) ? MW'(m_reg) * MW'(snx) : MW'(m_reg) * MW'(sny);
        ms_sh = ms >>> FRAC_BITS;

        tx     = TW'(sum_x_reg) + TW'(defx_reg) + TW'(memx_reg);
        ty     = TW'(sum_y_reg) + TW'(defy_reg) + TW'(memy_reg);
        tx_sat = sat32(64'(tx));
        ty_sat = sat32(64'(ty));

        // Unit-vector division: integer part first, so the remainder starts
        // below the divisor and only FRAC_BITS+1 quotient bits are needed.
        rd_ctl.start_root = (state_reg == S_SQB);
        rd_ctl.start_div  = ((state_reg == S_ROOT) && rd_done && (rd_root != '0))
                            || (state_reg == S_AMY);
        if (state_reg == S_AMY)
        begin
            rd_d     = {1'b0, ent_reg.area};
            rd_rem   = '0;
            rd_acc_x = prod_reg;
            rd_acc_y = pa_mag[DW-1:0];
            rd_n     = CW'(DW);
        end
        else
        begin
            rd_d     = rd_root;
            rd_rem   = {1'b0, ax_reg[31:1]};
            rd_acc_x = {ax_reg[0], {(DW-1){1'b0}}};
            rd_acc_y = {ay_reg[0], {(DW-1){1'b0}}};
            rd_n     = CW'(FRAC_BITS + 1);
        end
    end

    vnapf_root_div #(
        .DW (DW),
        .CW (CW)
    ) u_root_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (rd_ctl),
        .sq_in      ({1'b0, sq_sum}),
        .div_d      (rd_d),
        .rem_x_init (rd_rem),
        .rem_y_init (state_reg == S_AMY ? rd_rem : {1'b0, ay_reg[31:1]}),
        .acc_x_init (rd_acc_x),
        .acc_y_init (rd_acc_y),
        .div_n      (rd_n),
        .done       (rd_done),
        .root       (rd_root),
        .quo_x      (rd_qx),
        .quo_y      (rd_qy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vec_reg       <= VEC_CW;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        ent_reg   <= q_entry;
                        vec_reg   <= VEC_CW;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    ax_reg    <= halve ? mag_x[32:1] : mag_x[31:0];
                    ay_reg    <= halve ? mag_y[32:1] : mag_y[31:0];
                    sgx_reg   <= sel_dx[32];
                    sgy_reg   <= sel_dy[32];
                    state_reg <= S_SQA;
                end
                S_SQA:
                begin
                    sq_reg    <= ax_sq;
                    state_reg <= S_SQB;
                end
                S_SQB:
                begin
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (rd_done)
                    begin
                        if (rd_root == '0)
                        begin
                            // Zero-length vector: unit vector is zero and flagged.
                            err_reg <= 1'b1;
                            case (vec_reg)
                                VEC_CW:
                                begin
                                    cwx_reg <= '0;
                                    cwy_reg <= '0;
                                end
                                VEC_ACW:
                                begin
                                    awx_reg <= '0;
                                    awy_reg <= '0;
                                end
                                default:
                                begin
                                    nrx_reg <= '0;
                                    nry_reg <= '0;
                                end
                            endcase
                            if (vec_reg == VEC_NRM)
                            begin
                                state_reg <= S_AMX;
                            end
                            else
                            begin
                                vec_reg   <= vec_t'(vec_reg + 2'd1);
                                state_reg <= S_LOAD;
                            end
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (rd_done)
                    begin
                        case (vec_reg)
                            VEC_CW:
                            begin
                                cwx_reg <= ux_val;
                                cwy_reg <= uy_val;
                            end
                            VEC_ACW:
                            begin
                                awx_reg <= ux_val;
                                awy_reg <= uy_val;
                            end
                            default:
                            begin
                                nrx_reg <= ux_val;
                                nry_reg <= uy_val;
                            end
                        endcase
                        if (vec_reg == VEC_NRM)
                        begin
                            state_reg <= S_AMX;
                        end
                        else
                        begin
                            vec_reg   <= vec_t'(vec_reg + 2'd1);
                            state_reg <= S_LOAD;
                        end
                    end
                end
                S_AMX:
                begin
                    if (ent_reg.area_zero)
                    begin
                        err_reg   <= 1'b1;
                        defx_reg  <= '0;
                        defy_reg  <= '0;
                        state_reg <= S_TENS;
                    end
                    else
                    begin
                        prod_reg  <= pa_mag[DW-1:0];
                        negx_reg  <= pa[AW-1];
                        state_reg <= S_AMY;
                    end
                end
                S_AMY:
                begin
                    negy_reg  <= pa[AW-1];
                    state_reg <= S_ADIV;
                end
                S_ADIV:
                begin
                    if (rd_done)
                    begin
                        defx_reg  <= negx_reg ? -qx_mag : qx_mag;
                        defy_reg  <= negy_reg ? -qy_mag : qy_mag;
                        state_reg <= S_TENS;
                    end
                end
                S_TENS:
                begin
                    m_reg     <= m_sat[31:0];
                    err_reg   <= err_reg | m_sat[32];
                    state_reg <= S_MX;
                end
                S_MX:
                begin
                    memx_reg  <= ms_sh[33:0];
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    memy_reg  <= ms_sh[33:0];
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sum_x_reg <= tx_sat[31:0];
                    sum_y_reg <= ty_sat[31:0];
                    err_reg   <= err_reg | tx_sat[32] | ty_sat[32];
                    state_reg <= ent_reg.last ? S_EMIT : S_IDLE;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg  <= 1'b1;
                        force_x_reg    <= sum_x_reg;
                        force_y_reg    <= sum_y_reg;
                        math_error_reg <= err_reg;
                        sum_x_reg      <= '0;
                        sum_y_reg      <= '0;
                        err_reg        <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/vnapf_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the force accumulator, bound to the top level.
// Depends only on the top level's ports.
module vnapf_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] force_x,
    input logic signed [31:0] force_y,
    input logic               math_error
);

    // Reset empties the queue and drops any pending total.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> (in_ready && !out_valid))
        else $error("queue or output not cleared in reset");

    // A stalled total holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(force_x) && $stable(force_y) && $stable(math_error)))
        else $error("output word changed while stalled");

    // A new total never follows a taken one in the next cycle.
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> !out_valid)
        else $error("output word repeated right after acceptance");

endmodule

bind vertex_node_area_perimeter_force vnapf_port_checker u_vnapf_checker (.*);

/* dv/vnapf_checker.sv */
`timescale 1ns / 1ps
// Force checker for the vertex node area/perimeter force block: it watches the
// configuration port and both word channels, predicts every node total and compares.
// Depends on vnapf_pkg.
module vnapf_checker
    import vnapf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic signed [31:0]    node_x,
    input  logic signed [31:0]    node_y,
    input  logic signed [31:0]    prev_x,
    input  logic signed [31:0]    prev_y,
    input  logic signed [31:0]    next_x,
    input  logic signed [31:0]    next_y,
    input  logic [30:0]           elem_area,
    input  logic [30:0]           elem_perimeter,
    input  logic                  last_elem,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic signed [31:0]    force_x,
    input  logic signed [31:0]    force_y,
    input  logic                  math_error,
    output int                    fail_count,
    output int                    totals_pending
);

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               err;
    } node_total_t;

    node_total_t totals_q[$];
    longint      area_coef;
    longint      perim_coef;
    longint      acc_x;
    longint      acc_y;
    bit          acc_err;

    function automatic longint clamp32(input longint v, inout bit err);
        if (v > 64'sd2147483647) begin
            err = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            err = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Direction of (dx,dy) scaled to one; a zero-length vector gives zero and an error.
    task automatic unit_dir(input longint dx, input longint dy,
                            output longint ux, output longint uy, inout bit err);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned len;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        len = root64(ax * ax + ay * ay);
        if (len == 0) begin
            err = 1'b1;
            ux  = 0;
            uy  = 0;
        end
        else begin
            ux = longint'((ax << FB) / len);
            uy = longint'((ay << FB) / len);
            if (dx < 0) ux = -ux;
            if (dy < 0) uy = -uy;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("force check: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic add_element();
        longint cwx, cwy, awx, awy, sx, sy, nx, ny, ax_t, ay_t, m, mx, my;
        bit     err;
        node_total_t t;
        err  = 1'b0;
        ax_t = 0;
        ay_t = 0;
        unit_dir(longint'(prev_x) - longint'(node_x), longint'(prev_y) - longint'(node_y),
                 cwx, cwy, err);
        unit_dir(longint'(next_x) - longint'(node_x), longint'(next_y) - longint'(node_y),
                 awx, awy, err);
        sx = cwx + awx;
        sy = cwy + awy;
        unit_dir(-sx, -sy, nx, ny, err);
        if (elem_area == 0) begin
            err = 1'b1;
        end
        else begin
            ax_t = (area_coef * nx) / longint'(elem_area);
            ay_t = (area_coef * ny) / longint'(elem_area);
        end
        m  = clamp32((perim_coef * longint'(elem_perimeter)) >>> FB, err);
        mx = (m * sx) >>> FB;
        my = (m * sy) >>> FB;
        acc_x = clamp32(acc_x + ax_t + mx, err);
        acc_y = clamp32(acc_y + ay_t + my, err);
        acc_err = acc_err | err;
        if (last_elem) begin
            t.fx  = acc_x[31:0];
            t.fy  = acc_y[31:0];
            t.err = acc_err;
            totals_q.push_back(t);
            acc_x   = 0;
            acc_y   = 0;
            acc_err = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        node_total_t want;
        if (!rst_n) begin
            area_coef      = longint'(1) << FB;
            perim_coef     = longint'(1) << FB;
            acc_x          = 0;
            acc_y          = 0;
            acc_err        = 1'b0;
            fail_count     = 0;
            totals_pending = 0;
            totals_q.delete();
        end
        else begin
            if (cfg_we) begin
                if (cfg_addr == REG_AREA_PARAM)
                    area_coef = longint'(signed'(cfg_wdata));
                else if (cfg_addr == REG_PERIM_PARAM)
                    perim_coef = longint'(signed'(cfg_wdata));
            end
            if (out_valid && out_ready) begin
                if (totals_q.size() == 0) begin
                    report_mismatch("unexpected word, force_x", force_x, 0);
                end
                else begin
                    want = totals_q.pop_front();
                    if (force_x !== want.fx)
                        report_mismatch("force_x", force_x, want.fx);
                    if (force_y !== want.fy)
                        report_mismatch("force_y", force_y, want.fy);
                    if (math_error !== want.err)
                        report_mismatch("math_error", math_error, want.err);
                end
            end
            if (in_valid && in_ready)
                add_element();
            totals_pending = totals_q.size();
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for vertex_node_area_perimeter_force: clock, reset, stimulus
// and the final verdict. Depends on vnapf_pkg and vnapf_checker.
module tb_top;
    import vnapf_pkg::*;

    // A correct run stays far below this cap; the margin covers stalls on both sides
    // and the pauses between configuration phases.
    localparam int CYCLE_CAP  = 2_500_000;
    // Cycles to let the back end finish a word that closes no node.
    localparam int SETTLE     = 4 * FRAC_BITS_DEF + 200;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [31:0]           cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic signed [31:0]    node_x, node_y, prev_x, prev_y, next_x, next_y;
    logic [30:0]           elem_area;
    logic [30:0]           elem_perimeter;
    logic                  last_elem;
    logic                  out_valid;
    logic                  out_ready;
    logic signed [31:0]    force_x;
    logic signed [31:0]    force_y;
    logic                  math_error;
    int                    fail_count;
    int                    totals_pending;
    int                    cycle_count = 0;
    int                    burst_left;
    int                    ready_mode;

    vertex_node_area_perimeter_force u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .node_x         (node_x),
        .node_y         (node_y),
        .prev_x         (prev_x),
        .prev_y         (prev_y),
        .next_x         (next_x),
        .next_y         (next_y),
        .elem_area      (elem_area),
        .elem_perimeter (elem_perimeter),
        .last_elem      (last_elem),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .force_x        (force_x),
        .force_y        (force_y),
        .math_error     (math_error)
    );

    vnapf_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .node_x         (node_x),
        .node_y         (node_y),
        .prev_x         (prev_x),
        .prev_y         (prev_y),
        .next_x         (next_x),
        .next_y         (next_y),
        .elem_area      (elem_area),
        .elem_perimeter (elem_perimeter),
        .last_elem      (last_elem),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .force_x        (force_x),
        .force_y        (force_y),
        .math_error     (math_error),
        .fail_count     (fail_count),
        .totals_pending (totals_pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Global watchdog. A run that hits the cap is a failure on its own.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("[vertex_node_area_perimeter_force] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure. The mode changes now and then, so we get stretches
    // of a always-ready receiver, light random stalls and long stalls.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready  = 1'b0;
            ready_mode = 0;
        end
        else begin
            if ($urandom_range(0, 199) == 0)
                ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0:       out_ready = 1'b1;
                1:       out_ready = ($urandom_range(0, 3) != 0);
                2:       out_ready = ($urandom_range(0, 1) != 0);
                default: out_ready = ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // One register write, driven on the falling edge and held for one cycle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Present one word and hold it until the block takes it. The sender works in
    // bursts; at the end of a burst valid drops for a random gap.
    task automatic send_word(input logic signed [31:0] nx, input logic signed [31:0] ny,
                             input logic signed [31:0] px, input logic signed [31:0] py,
                             input logic signed [31:0] qx, input logic signed [31:0] qy,
                             input logic [30:0] area, input logic [30:0] perim,
                             input logic last);
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        node_x         = nx;
        node_y         = ny;
        prev_x         = px;
        prev_y         = py;
        next_x         = qx;
        next_y         = qy;
        elem_area      = area;
        elem_perimeter = perim;
        last_elem      = last;
        in_valid       = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected total, then let the back end settle.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (totals_pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // A small random offset from a center, scaled so sums mostly stay in range.
    function automatic logic signed [31:0] near(input logic signed [31:0] c, input int span);
        return c + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // One node with a few elements. Most nodes use well-formed local geometry;
    // some use raw full-range values so every bit of every field toggles.
    task automatic send_node(input bit noisy);
        int                 n_elems;
        int                 span;
        logic signed [31:0] cx, cy;
        logic [30:0]        area;
        logic [30:0]        perim;
        n_elems = $urandom_range(1, 5);
        span    = 1 << $urandom_range(4, 22);
        cx      = $urandom;
        cy      = $urandom;
        for (int e = 0; e < n_elems; e++) begin
            if (noisy) begin
                area  = 31'($urandom);
                perim = 31'($urandom);
                send_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          area, perim, e == n_elems - 1);
            end
            else begin
                // Zero area and zero perimeter now and then; otherwise moderate sizes.
                area  = ($urandom_range(0, 15) == 0) ? 31'd0 : 31'($urandom_range(1, 1 << 24));
                perim = ($urandom_range(0, 15) == 0) ? 31'd0 : 31'($urandom_range(0, 1 << 20));
                send_word(cx, cy, near(cx, span), near(cy, span), near(cx, span),
                          near(cy, span), area, perim, e == n_elems - 1);
            end
        end
    endtask

    task automatic run_directed();
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        // Plain unit square corner, then the same node closed with a second element.
        send_word(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000, 31'h0001_0000, 31'h0004_0000,
                  1'b0);
        send_word(0, 0, 0, 32'sh0001_0000, -32'sh0001_0000, 0, 31'h0001_0000,
                  31'h0004_0000, 1'b1);
        // Zero-length vector: the previous vertex sits on the node.
        send_word(5, 7, 5, 7, 100, 7, 31'h0001_0000, 31'h0001_0000, 1'b1);
        // Both neighbors on the node: every unit vector and the normal are zero.
        send_word(9, 9, 9, 9, 9, 9, 31'h0001_0000, 31'h0001_0000, 1'b1);
        // Opposite neighbors: the two unit vectors cancel and the normal has no length.
        send_word(0, 0, -32'sh0002_0000, 0, 32'sh0002_0000, 0, 31'h0001_0000, 31'h0001_0000,
                  1'b1);
        // Zero area.
        send_word(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000, 31'd0, 31'h0001_0000, 1'b1);
        // Smallest nonzero area drives the area term large.
        send_word(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000, 31'd1, 31'd0, 1'b1);
        // Largest area and perimeter: the tension coefficient lands exactly on its largest value.
        send_word(0, 0, 32'sh0001_0000, 0, 0, -32'sh0001_0000, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 1'b1);
        // Extreme coordinates: differences need 33 bits and get halved before the root.
        send_word(mn, mn, mx, mx, mx, mn, 31'h7FFF_FFFF, 31'd0, 1'b1);
        send_word(mx, mx, mn, mn, mn, mx, 31'd1, 31'h7FFF_FFFF, 1'b1);
        send_word(mx, mn, mn, mx, mx, mx, 31'h0000_0100, 31'h0000_0100, 1'b0);
        send_word(mn, mx, mx, mn, mn, mn, 31'h0000_0100, 31'h0000_0100, 1'b0);
        // A long node of large terms saturates the running sum.
        for (int k = 0; k < 6; k++)
            send_word(0, 0, 32'sh0001_0000, 1, 32'sh0001_0000, -1, 31'd1, 31'h7FFF_FFFF,
                      k == 5);
        // The error flag clears after an emit: a clean node follows.
        send_word(0, 0, 32'sh0003_0000, 0, 0, 32'sh0004_0000, 31'h0010_0000, 31'h0001_0000,
                  1'b1);
        // All-zero word.
        send_word(0, 0, 0, 0, 0, 0, 31'd0, 31'd0, 1'b1);
    endtask

    initial begin
        logic [31:0] area_vals[5];
        logic [31:0] perim_vals[5];
        burst_left     = 0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_AREA_PARAM;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        node_x         = '0;
        node_y         = '0;
        prev_x         = '0;
        prev_y         = '0;
        next_x         = '0;
        next_y         = '0;
        elem_area      = '0;
        elem_perimeter = '0;
        last_elem      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // First phase runs on the reset coefficients of 1.0.
        run_directed();

        // Coefficient settings per phase: defaults, both extremes, zero and random.
        area_vals  = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, $urandom};
        perim_vals = '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, $urandom};
        for (int ph = 0; ph < 5; ph++) begin
            // Registers change only once the block has drained completely.
            wait_idle();
            write_reg(REG_AREA_PARAM, area_vals[ph]);
            write_reg(REG_PERIM_PARAM, perim_vals[ph]);
            for (int n = 0; n < 70; n++)
                send_node($urandom_range(0, 9) == 0);
            // Random coefficients once more within this phase, after a full drain.
            if (ph == 4) begin
                wait_idle();
                write_reg(REG_AREA_PARAM, $urandom);
                write_reg(REG_PERIM_PARAM, $urandom);
                for (int n = 0; n < 30; n++)
                    send_node($urandom_range(0, 9) == 0);
            end
        end

        in_valid = 1'b0;
        while (totals_pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (fail_count == 0 && totals_pending == 0)
            $display("[vertex_node_area_perimeter_force] OK");
        else
            $display("[vertex_node_area_perimeter_force] ERROR");
        $finish;
    end

endmodule
